@@ src/ycs_pkg.sv @@
`default_nettype none
package ycs_pkg;

	// channel mode codes
	localparam logic [1:0] MODE_MID  = 2'd0;
	localparam logic [1:0] MODE_KEEP = 2'd1;
	localparam logic [1:0] MODE_ZERO = 2'd2;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_MODE_LUMA      = 2'd0;
	localparam logic [1:0] REG_MODE_BLUE_DIFF = 2'd1;
	localparam logic [1:0] REG_MODE_RED_DIFF  = 2'd2;

	localparam int unsigned PIX_W = 8;

	typedef struct packed {
		logic [1:0] luma;
		logic [1:0] blue_diff;
		logic [1:0] red_diff;
	} mode_set_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	// magnitude in units of 1e-4, rounded half up to f fraction bits
	function automatic longint unsigned qmag(longint unsigned m, int unsigned f);
		return ((m << f) + 64'd5000) / 64'd10000;
	endfunction

endpackage
`default_nettype wire

@@ src/ycs_rnd_clamp.sv @@
`default_nettype none
module ycs_rnd_clamp #(
	parameter int unsigned F     = 14,
	parameter int unsigned ACC_W = 25
) (
	input  wire logic signed [ACC_W-1:0] acc,
	output logic [ycs_pkg::PIX_W-1:0]    q
);

	localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (F - 1);

	logic [ACC_W-1:0] biased;
	logic [ACC_W-1:0] shifted;

	always_comb begin
		biased  = acc + HALF;
		shifted = biased >> F;
		// a negative sum rounds to zero or below: clamp to zero
		if (acc[ACC_W-1]) begin
			q = '0;
		end else if (|shifted[ACC_W-1:ycs_pkg::PIX_W]) begin
			q = '1;
		end else begin
			q = shifted[ycs_pkg::PIX_W-1:0];
		end
	end

endmodule
`default_nettype wire

@@ src/ycs_fwd.sv @@
`default_nettype none
module ycs_fwd #(
	parameter int unsigned F = 14
) (
	input  wire logic                        clk,
	input  wire ycs_pkg::pipe_en_t           en,
	input  wire ycs_pkg::mode_set_t          mode,
	input  wire logic [ycs_pkg::PIX_W-1:0]   red,
	input  wire logic [ycs_pkg::PIX_W-1:0]   green,
	input  wire logic [ycs_pkg::PIX_W-1:0]   blue,
	output logic [ycs_pkg::PIX_W-1:0]        y_s2,
	output logic [ycs_pkg::PIX_W-1:0]        cb_s2,
	output logic [ycs_pkg::PIX_W-1:0]        cr_s2
);

	localparam int unsigned CW    = F + 2;
	localparam int unsigned PW    = CW + ycs_pkg::PIX_W;
	localparam int unsigned ACC_W = F + 11;

	localparam logic [CW-1:0] C_Y_R  = CW'(ycs_pkg::qmag(64'd2990, F));
	localparam logic [CW-1:0] C_Y_G  = CW'(ycs_pkg::qmag(64'd5870, F));
	localparam logic [CW-1:0] C_Y_B  = CW'(ycs_pkg::qmag(64'd1140, F));
	localparam logic [CW-1:0] C_CB_R = CW'(ycs_pkg::qmag(64'd1687, F));
	localparam logic [CW-1:0] C_CB_G = CW'(ycs_pkg::qmag(64'd3313, F));
	localparam logic [CW-1:0] C_HALF = CW'(ycs_pkg::qmag(64'd5000, F));
	localparam logic [CW-1:0] C_CR_G = CW'(ycs_pkg::qmag(64'd4187, F));
	localparam logic [CW-1:0] C_CR_B = CW'(ycs_pkg::qmag(64'd813, F));
	localparam logic [ACC_W-1:0] OFF = ACC_W'(128) << F;

	logic [PW-1:0] p_yr_s1, p_yg_s1, p_yb_s1;
	logic [PW-1:0] p_cbr_s1, p_cbg_s1, p_cbb_s1;
	logic [PW-1:0] p_crr_s1, p_crg_s1, p_crb_s1;

	logic signed [ACC_W-1:0] y_acc, cb_acc, cr_acc;
	logic [ycs_pkg::PIX_W-1:0] y_rc, cb_rc, cr_rc;

	// stage 1: magnitudes of the nine products, signs applied in the sum
	always_ff @(posedge clk) begin
		if (en.s1) begin
			p_yr_s1  <= PW'(red)   * PW'(C_Y_R);
			p_yg_s1  <= PW'(green) * PW'(C_Y_G);
			p_yb_s1  <= PW'(blue)  * PW'(C_Y_B);
			p_cbr_s1 <= PW'(red)   * PW'(C_CB_R);
			p_cbg_s1 <= PW'(green) * PW'(C_CB_G);
			p_cbb_s1 <= PW'(blue)  * PW'(C_HALF);
			p_crr_s1 <= PW'(red)   * PW'(C_HALF);
			p_crg_s1 <= PW'(green) * PW'(C_CR_G);
			p_crb_s1 <= PW'(blue)  * PW'(C_CR_B);
		end
	end

	always_comb begin
		y_acc  = ACC_W'(p_yr_s1) + ACC_W'(p_yg_s1) + ACC_W'(p_yb_s1);
		cb_acc = ACC_W'(p_cbb_s1) - ACC_W'(p_cbr_s1) - ACC_W'(p_cbg_s1) + OFF;
		cr_acc = ACC_W'(p_crr_s1) - ACC_W'(p_crg_s1) - ACC_W'(p_crb_s1) + OFF;
	end

	ycs_rnd_clamp #(.F(F), .ACC_W(ACC_W)) u_rc_y  (.acc(y_acc),  .q(y_rc));
	ycs_rnd_clamp #(.F(F), .ACC_W(ACC_W)) u_rc_cb (.acc(cb_acc), .q(cb_rc));
	ycs_rnd_clamp #(.F(F), .ACC_W(ACC_W)) u_rc_cr (.acc(cr_acc), .q(cr_rc));

	function automatic logic [ycs_pkg::PIX_W-1:0] pick(
		input logic [1:0]                m,
		input logic [ycs_pkg::PIX_W-1:0] v
	);
		logic [ycs_pkg::PIX_W-1:0] r;
		case (m)
			ycs_pkg::MODE_MID:  r = ycs_pkg::PIX_W'(128);
			ycs_pkg::MODE_KEEP: r = v;
			default:            r = '0;
		endcase
		return r;
	endfunction

	// stage 2: round, clamp, apply channel mode
	always_ff @(posedge clk) begin
		if (en.s2) begin
			y_s2  <= pick(mode.luma, y_rc);
			cb_s2 <= pick(mode.blue_diff, cb_rc);
			cr_s2 <= pick(mode.red_diff, cr_rc);
		end
	end

endmodule
`default_nettype wire

@@ src/ycs_inv.sv @@
`default_nettype none
module ycs_inv #(
	parameter int unsigned F = 14
) (
	input  wire logic                      clk,
	input  wire ycs_pkg::pipe_en_t         en,
	input  wire logic [ycs_pkg::PIX_W-1:0] y,
	input  wire logic [ycs_pkg::PIX_W-1:0] cb,
	input  wire logic [ycs_pkg::PIX_W-1:0] cr,
	output logic [ycs_pkg::PIX_W-1:0]      red_s4,
	output logic [ycs_pkg::PIX_W-1:0]      green_s4,
	output logic [ycs_pkg::PIX_W-1:0]      blue_s4
);

	localparam int unsigned CW    = F + 3;
	localparam int unsigned DW    = ycs_pkg::PIX_W + 1;
	localparam int unsigned PW    = CW + DW;
	localparam int unsigned ACC_W = F + 13;

	localparam logic signed [CW-1:0] C_R_CR = CW'(ycs_pkg::qmag(64'd14020, F));
	localparam logic signed [CW-1:0] C_G_CB = CW'(ycs_pkg::qmag(64'd3441, F));
	localparam logic signed [CW-1:0] C_G_CR = CW'(ycs_pkg::qmag(64'd7141, F));
	localparam logic signed [CW-1:0] C_B_CB = CW'(ycs_pkg::qmag(64'd17720, F));

	logic signed [DW-1:0] cbd, crd;
	logic [ycs_pkg::PIX_W-1:0] y_s3;
	logic signed [PW-1:0] p_rcr_s3, p_gcb_s3, p_gcr_s3, p_bcb_s3;

	logic signed [ACC_W-1:0] yq, r_acc, g_acc, b_acc;
	logic [ycs_pkg::PIX_W-1:0] r_rc, g_rc, b_rc;

	// remove the chroma offset
	assign cbd = $signed({1'b0, cb}) - $signed(DW'(128));
	assign crd = $signed({1'b0, cr}) - $signed(DW'(128));

	// stage 3: chroma products
	always_ff @(posedge clk) begin
		if (en.s3) begin
			y_s3     <= y;
			p_rcr_s3 <= PW'(crd) * PW'(C_R_CR);
			p_gcb_s3 <= PW'(cbd) * PW'(C_G_CB);
			p_gcr_s3 <= PW'(crd) * PW'(C_G_CR);
			p_bcb_s3 <= PW'(cbd) * PW'(C_B_CB);
		end
	end

	always_comb begin
		yq    = ACC_W'(y_s3) << F;
		r_acc = yq + ACC_W'(p_rcr_s3);
		g_acc = yq - ACC_W'(p_gcb_s3) - ACC_W'(p_gcr_s3);
		b_acc = yq + ACC_W'(p_bcb_s3);
	end

	ycs_rnd_clamp #(.F(F), .ACC_W(ACC_W)) u_rc_r (.acc(r_acc), .q(r_rc));
	ycs_rnd_clamp #(.F(F), .ACC_W(ACC_W)) u_rc_g (.acc(g_acc), .q(g_rc));
	ycs_rnd_clamp #(.F(F), .ACC_W(ACC_W)) u_rc_b (.acc(b_acc), .q(b_rc));

	// stage 4: output register
	always_ff @(posedge clk) begin
		if (en.s4) begin
			red_s4   <= r_rc;
			green_s4 <= g_rc;
			blue_s4  <= b_rc;
		end
	end

endmodule
`default_nettype wire

@@ src/ycbcr_channel_select_roundtrip.sv @@
// RGB -> YCbCr -> RGB round trip with a mode per channel (keep, mid grey, zero).
// Input stream: s_axis_*, one RGB pixel per transaction, red in the lowest byte.
// Output stream: m_axis_*, one RGB pixel per input transaction, same packing.
// Configuration: APB port, three 2-bit mode registers at byte addresses
//   0 (luma), 4 (blue difference), 8 (red difference); pready is tied high.
//   Write them only while no pixel is in flight.
// Pipeline: four register stages - forward products, forward round/clamp and
//   mode select, inverse products, inverse round/clamp into the output register.
// Path: an accepted input passes the four stage registers in order; m_axis_tvalid is the stage 4 valid bit.
// Throughput: one pixel per clock while the receiver takes each result, with one
//   multiplier per product in the two product stages (1 and 3).
// Each stage carries a valid bit and advances when it is empty or the stage
//   after it advances, so bubbles collapse and s_axis_tready stays high while
//   any stage has room, even with a result waiting at the output.
// Receiver stall: the output register holds its pixel; stages fill up behind
//   it and s_axis_tready drops once all four are full. Nothing is lost.
// Reset: all valid bits clear and every mode returns to keep.
`default_nettype none
module ycbcr_channel_select_roundtrip #(
	parameter int unsigned COEF_FRAC_BITS = 14
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // red_in [7:0], green_in [15:8], blue_in [23:16]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // red_out [7:0], green_out [15:8], blue_out [23:16]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [1:0] mode_luma_q, mode_blue_diff_q, mode_red_diff_q;
	ycs_pkg::mode_set_t mode;
	ycs_pkg::pipe_en_t  en;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic wr_en;

	logic [ycs_pkg::PIX_W-1:0] y_s2, cb_s2, cr_s2;
	logic [ycs_pkg::PIX_W-1:0] red_s4, green_s4, blue_s4;

	// ---- configuration port ----
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_luma_q      <= ycs_pkg::MODE_KEEP;
			mode_blue_diff_q <= ycs_pkg::MODE_KEEP;
			mode_red_diff_q  <= ycs_pkg::MODE_KEEP;
		end else if (wr_en) begin
			// writes beyond the last register drop silently
			case (paddr[3:2])
				ycs_pkg::REG_MODE_LUMA:      mode_luma_q      <= pwdata[1:0];
				ycs_pkg::REG_MODE_BLUE_DIFF: mode_blue_diff_q <= pwdata[1:0];
				ycs_pkg::REG_MODE_RED_DIFF:  mode_red_diff_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ycs_pkg::REG_MODE_LUMA:      prdata = {30'd0, mode_luma_q};
			ycs_pkg::REG_MODE_BLUE_DIFF: prdata = {30'd0, mode_blue_diff_q};
			ycs_pkg::REG_MODE_RED_DIFF:  prdata = {30'd0, mode_red_diff_q};
			default:                     prdata = 32'd0;
		endcase
	end

	assign mode = '{luma: mode_luma_q, blue_diff: mode_blue_diff_q,
		red_diff: mode_red_diff_q};

	// ---- pipeline control: a stage advances when empty or its successor advances ----
	assign rdy4 = ~v_s4 | m_axis_tready;
	assign rdy3 = ~v_s3 | rdy4;
	assign rdy2 = ~v_s2 | rdy3;
	assign rdy1 = ~v_s1 | rdy2;

	assign en = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign s_axis_tready = rdy1;
	assign m_axis_tvalid = v_s4;

	// ---- datapath ----
	ycs_fwd #(.F(COEF_FRAC_BITS)) u_fwd (
		.clk   (clk),
		.en    (en),
		.mode  (mode),
		.red   (s_axis_tdata[7:0]),
		.green (s_axis_tdata[15:8]),
		.blue  (s_axis_tdata[23:16]),
		.y_s2  (y_s2),
		.cb_s2 (cb_s2),
		.cr_s2 (cr_s2)
	);

	ycs_inv #(.F(COEF_FRAC_BITS)) u_inv (
		.clk      (clk),
		.en       (en),
		.y        (y_s2),
		.cb       (cb_s2),
		.cr       (cr_s2),
		.red_s4   (red_s4),
		.green_s4 (green_s4),
		.blue_s4  (blue_s4)
	);

	assign m_axis_tdata = {blue_s4, green_s4, red_s4};

endmodule
`default_nettype wire

@@ src/ycs_checker.sv @@
`default_nettype none
module ycs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [3:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic        pready
);

	logic luma_wr;
	assign luma_wr = psel & penable & pwrite & pready
		& (paddr[3:2] == ycs_pkg::REG_MODE_LUMA);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transaction dropped or changed while stalled");

	// with the output stage free to move, the whole pipeline takes input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("input stalled while the output stage can advance");

	// a written luma mode reads back
	a_luma_readback: assert property (@(posedge clk) disable iff (!arst_n)
		luma_wr ##1 (paddr[3:2] == ycs_pkg::REG_MODE_LUMA)
		|-> prdata[1:0] == $past(pwdata[1:0]))
		else $error("luma mode register did not take the write");

	// upper register bits read as zero, and the port never waits
	a_reg_width: assert property (@(posedge clk) disable iff (!arst_n)
		pready && prdata[31:2] == 30'd0)
		else $error("register read returned bits beyond the mode field");

endmodule

bind ycbcr_channel_select_roundtrip ycs_checker u_ycs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.pwdata        (pwdata),
	.prdata        (prdata),
	.pready        (pready)
);
`default_nettype wire
